### src/boxcar_moving_average_top_macros.svh
// ----------------------------------------------------------------------------
// boxcar moving average assertion macros
// Property helpers for the filter's concurrent checks; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BOXCAR_MOVING_AVERAGE_TOP_MACROS_SVH
`define BOXCAR_MOVING_AVERAGE_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define BMA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle check");
// next-cycle implication
`define BMA_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle check");
`else
`define BMA_ASSERT_IMP(lbl, ante, cons)
`define BMA_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

### src/bma_pkg.sv
// ----------------------------------------------------------------------------
// bma_pkg
// Shared constants and types of the boxcar moving average filter.
// ----------------------------------------------------------------------------
`default_nettype none

package bma_pkg;

  localparam int unsigned MAX_WINDOW_DEF  = 64;
  localparam int unsigned SAMPLE_BITS_DEF = 16;
  localparam int unsigned LEN_BITS        = 7;
  localparam int unsigned MEAN_BITS       = 16;

  localparam logic [LEN_BITS-1:0] WINDOW_LEN_RST = LEN_BITS'(8);

  // control from the sequencer to the serial sum unit
  typedef struct packed {
    logic start;
    logic prime;
  } bma_sum_ctl_t;

endpackage

`default_nettype wire

### src/bma_sample_if.sv
// ----------------------------------------------------------------------------
// bma_sample_if
// Valid/ready channel carrying one distance sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface bma_sample_if #(
  parameter int unsigned SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] distance_sample;

  modport source (output valid, output distance_sample, input ready);
  modport sink   (input valid, input distance_sample, output ready);
endinterface

`default_nettype wire

### src/bma_mean_if.sv
// ----------------------------------------------------------------------------
// bma_mean_if
// Valid/ready channel carrying one window mean.
// ----------------------------------------------------------------------------
`default_nettype none

interface bma_mean_if;
  import bma_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [MEAN_BITS-1:0] mean_distance;

  modport source (output valid, output mean_distance, input ready);
  modport sink   (input valid, input mean_distance, output ready);
endinterface

`default_nettype wire

### src/boxcar_moving_average_top.sv
// ----------------------------------------------------------------------------
// boxcar_moving_average_top
// Moving-average filter over the last N distance samples with a running sum.
// ----------------------------------------------------------------------------
// Usage:
//   sample_i takes one distance sample per request; mean_o returns one window
//   mean per sample, in order. cfg_we_i/cfg_wdata_i write the window length
//   (0 acts as 1, values above MAX_WINDOW act as MAX_WINDOW); write it only
//   while the filter is idle. A write re-primes the window.
//   The first sample after reset or a length write primes every slot with
//   its value and comes back unchanged once the serial multiply of length
//   by sample is done. Every later sample runs the bit-serial sum update
//   and then the bit-serial divider, each over SUM_BITS bits, with
//   SUM_BITS = SAMPLE_BITS + clog2(MAX_WINDOW).
//   One sample is in flight at a time; sample_i.ready is high while idle.
//   The mean sits in an output register, so a new sample is taken while the
//   last mean waits; a stalled receiver holds the next mean in the sequencer
//   until the output register frees up.
//   Reset idles the sum unit, length returns to 8, the window is unprimed
//   and no mean is pending. The sample ring is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

`include "boxcar_moving_average_top_macros.svh"

module boxcar_moving_average_top #(
  parameter int unsigned MAX_WINDOW  = bma_pkg::MAX_WINDOW_DEF,
  parameter int unsigned SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  bma_sample_if.sink                        sample_i,
  bma_mean_if.source                        mean_o,
  input  wire logic                         cfg_we_i,
  input  wire logic [bma_pkg::LEN_BITS-1:0] cfg_wdata_i
);
  import bma_pkg::*;

  localparam int unsigned SLOT_BITS = $clog2(MAX_WINDOW);
  localparam int unsigned SUM_BITS  = SAMPLE_BITS + SLOT_BITS;
  localparam int unsigned CMP_W     = ((SLOT_BITS > LEN_BITS) ? SLOT_BITS : LEN_BITS) + 1;

  localparam int unsigned ST_W = 3;
  localparam logic [ST_W-1:0] ST_IDLE = 3'd0;
  localparam logic [ST_W-1:0] ST_READ = 3'd1;
  localparam logic [ST_W-1:0] ST_SUM  = 3'd2;
  localparam logic [ST_W-1:0] ST_DIV  = 3'd3;
  localparam logic [ST_W-1:0] ST_OUT  = 3'd4;

  logic [ST_W-1:0]        state_q;
  logic [LEN_BITS-1:0]    wlen_q;
  logic                   primed_q;
  logic                   prime_q;
  logic [SLOT_BITS-1:0]   slot_q;
  logic [LEN_BITS-1:0]    written_q;
  logic                   out_valid_q;

  logic [SAMPLE_BITS-1:0] x_q;
  logic [SAMPLE_BITS-1:0] prime_val_q;
  logic [SLOT_BITS-1:0]   slot_use_q;
  logic [MEAN_BITS-1:0]   result_q;
  logic [MEAN_BITS-1:0]   out_data_q;

  logic [LEN_BITS-1:0]    n_eff;
  logic [SLOT_BITS-1:0]   slot_fix;
  logic [CMP_W-1:0]       slot_nxt;
  logic                   in_req;
  logic [SAMPLE_BITS-1:0] ram_rdata;
  logic [SAMPLE_BITS-1:0] old_val;
  bma_sum_ctl_t           sum_ctl;
  logic [SUM_BITS-1:0]    sum;
  logic                   sum_done;
  logic                   div_start;
  logic [SUM_BITS-1:0]    quot;
  logic                   div_done;

  always_comb begin
    if (wlen_q == '0) begin
      n_eff = LEN_BITS'(1);
    end else if (32'(wlen_q) > MAX_WINDOW) begin
      n_eff = LEN_BITS'(MAX_WINDOW);
    end else begin
      n_eff = wlen_q;
    end
    slot_fix = (CMP_W'(slot_q) >= CMP_W'(n_eff)) ? '0 : slot_q;
    slot_nxt = CMP_W'(slot_use_q) + CMP_W'(1);
    // slots not yet written since priming read as the priming value
    old_val  = (CMP_W'(slot_use_q) < CMP_W'(written_q)) ? ram_rdata : prime_val_q;
    sum_ctl.start = (state_q == ST_READ);
    sum_ctl.prime = prime_q;
    div_start = (state_q == ST_SUM) && sum_done && !prime_q;
  end

  assign sample_i.ready = (state_q == ST_IDLE);
  assign in_req         = sample_i.valid && sample_i.ready;

  bma_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    ((state_q == ST_READ) && !prime_q),
    .waddr_i (slot_use_q),
    .wdata_i (x_q),
    .re_i    (in_req),
    .raddr_i (slot_fix),
    .rdata_o (ram_rdata)
  );

  bma_sum #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .SUM_BITS    (SUM_BITS)
  ) u_sum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (sum_ctl),
    .n_i    (n_eff),
    .x_i    (x_q),
    .old_i  (old_val),
    .sum_o  (sum),
    .done_o (sum_done)
  );

  bma_div #(
    .SUM_BITS (SUM_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum),
    .divisor_i  (n_eff),
    .quot_o     (quot),
    .done_o     (div_done)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wlen_q      <= WINDOW_LEN_RST;
      primed_q    <= 1'b0;
      prime_q     <= 1'b0;
      slot_q      <= '0;
      written_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if ((state_q == ST_OUT) && (!out_valid_q || mean_o.ready)) begin
        out_valid_q <= 1'b1;
      end else if (mean_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_req) begin
            prime_q <= !primed_q;
            if (!primed_q) begin
              slot_q    <= '0;
              written_q <= '0;
            end
            state_q <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_SUM;
        end
        ST_SUM: begin
          if (sum_done) begin
            state_q <= prime_q ? ST_OUT : ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            if ((CMP_W'(written_q) < CMP_W'(n_eff)) && (slot_nxt > CMP_W'(written_q))) begin
              written_q <= LEN_BITS'(slot_nxt);
            end
            slot_q  <= (slot_nxt >= CMP_W'(n_eff)) ? '0 : SLOT_BITS'(slot_nxt);
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_q || mean_o.ready) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
      // a length write re-primes the window
      if (cfg_we_i) begin
        wlen_q   <= cfg_wdata_i;
        primed_q <= 1'b0;
      end else if (in_req && !primed_q) begin
        primed_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_req) begin
      x_q <= sample_i.distance_sample;
      if (!primed_q) begin
        prime_val_q <= sample_i.distance_sample;
        slot_use_q  <= '0;
        result_q    <= MEAN_BITS'(sample_i.distance_sample);
      end else begin
        slot_use_q  <= slot_fix;
      end
    end
    if ((state_q == ST_DIV) && div_done) begin
      result_q <= MEAN_BITS'(quot);
    end
    if ((state_q == ST_OUT) && (!out_valid_q || mean_o.ready)) begin
      out_data_q <= result_q;
    end
  end

  assign mean_o.valid         = out_valid_q;
  assign mean_o.mean_distance = out_data_q;

  `BMA_ASSERT_NXT(a_req_starts_read, in_req, state_q == ST_READ)
  `BMA_ASSERT_IMP(a_sum_done_in_sum, sum_done, state_q == ST_SUM)
  `BMA_ASSERT_IMP(a_div_done_in_div, div_done, state_q == ST_DIV)
  `BMA_ASSERT_IMP(a_slot_in_window, primed_q && (state_q == ST_IDLE), CMP_W'(slot_q) < CMP_W'(n_eff))

endmodule

`default_nettype wire

### src/bma_ram.sv
// ----------------------------------------------------------------------------
// bma_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/bma_sum.sv
// ----------------------------------------------------------------------------
// bma_sum
// Bit-serial running sum unit: sum - old + new, or length times sample.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_sum #(
  parameter int unsigned SAMPLE_BITS = bma_pkg::SAMPLE_BITS_DEF,
  parameter int unsigned SUM_BITS    = bma_pkg::SAMPLE_BITS_DEF + 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire bma_pkg::bma_sum_ctl_t        ctl_i,
  input  wire logic [bma_pkg::LEN_BITS-1:0] n_i,
  input  wire logic [SAMPLE_BITS-1:0]       x_i,
  input  wire logic [SAMPLE_BITS-1:0]       old_i,
  output logic      [SUM_BITS-1:0]          sum_o,
  output logic                              done_o
);
  import bma_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0]    sum_q;
  logic [SAMPLE_BITS-1:0] x_q;
  logic [SAMPLE_BITS-1:0] old_q;
  logic [LEN_BITS-1:0]    mcarry_q;
  logic signed [1:0]      acarry_q;
  logic [CNT_W-1:0]       cnt_q;
  logic                   busy_q;
  logic                   prime_q;
  logic                   done_q;

  logic [LEN_BITS:0]      t_mul;
  logic signed [2:0]      t_add;
  logic                   sum_bit;
  logic                   last;

  always_comb begin
    // serial-parallel multiply: product bits come out lsb first
    t_mul = {1'b0, mcarry_q} + (x_q[0] ? {1'b0, n_i} : '0);
    // signed digit carry in -1..1 covers the add and subtract together
    t_add = $signed({2'b00, sum_q[0]}) + $signed({2'b00, x_q[0]})
          - $signed({2'b00, old_q[0]}) + 3'(acarry_q);
    sum_bit = prime_q ? t_mul[0] : t_add[0];
    last    = (cnt_q == CNT_W'(SUM_BITS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q      <= x_i;
      old_q    <= old_i;
      mcarry_q <= '0;
      acarry_q <= '0;
      prime_q  <= ctl_i.prime;
    end else if (busy_q) begin
      x_q      <= x_q >> 1;
      old_q    <= old_q >> 1;
      mcarry_q <= t_mul[LEN_BITS:1];
      acarry_q <= t_add[2:1];
      sum_q    <= {sum_bit, sum_q[SUM_BITS-1:1]};
    end
  end

  assign sum_o  = sum_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### src/bma_div.sv
// ----------------------------------------------------------------------------
// bma_div
// Bit-serial restoring divider, one quotient bit per cycle, msb first.
// ----------------------------------------------------------------------------
`default_nettype none

module bma_div #(
  parameter int unsigned SUM_BITS = bma_pkg::SAMPLE_BITS_DEF + 6
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic [SUM_BITS-1:0]          dividend_i,
  input  wire logic [bma_pkg::LEN_BITS-1:0] divisor_i,
  output logic      [SUM_BITS-1:0]          quot_o,
  output logic                              done_o
);
  import bma_pkg::*;

  localparam int unsigned CNT_W = $clog2(SUM_BITS + 1);

  logic [SUM_BITS-1:0] dvd_q;
  logic [LEN_BITS-1:0] rem_q;
  logic [CNT_W-1:0]    cnt_q;
  logic                busy_q;
  logic                done_q;

  logic [LEN_BITS:0]   rem_sh;
  logic [LEN_BITS:0]   rem_sub;
  logic                ge;
  logic                last;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[SUM_BITS-1]};
    ge      = (rem_sh >= {1'b0, divisor_i});
    rem_sub = rem_sh - {1'b0, divisor_i};
    last    = (cnt_q == CNT_W'(SUM_BITS - 1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && last;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (last) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // dividend shifts out at the top while quotient bits fill in at the bottom
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[SUM_BITS-2:0], ge};
      rem_q <= ge ? rem_sub[LEN_BITS-1:0] : rem_sh[LEN_BITS-1:0];
    end
  end

  assign quot_o = dvd_q;
  assign done_o = done_q;

endmodule

`default_nettype wire

### tb/tb_boxcar_moving_average_top.sv
// ----------------------------------------------------------------------------
// tb_boxcar_moving_average_top
// Drives distance samples and window-length writes into the filter and
// checks every window mean against a cycle-free model of the ring and sum.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_boxcar_moving_average_top;
  import bma_pkg::*;

  localparam int unsigned SUM_W        = 22;
  localparam int unsigned RAND_SAMPLES = 1300;
  localparam int unsigned CALM_ITEMS   = 150;
  localparam int unsigned QUIET_CYCLES = 4;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned STALL_LIMIT  = 4000;

  typedef enum bit {
    REQ_SAMPLE,
    REQ_LEN_WRITE
  } req_kind_e;

  typedef struct {
    req_kind_e   kind;
    logic [15:0] value;
  } filter_req_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [LEN_BITS-1:0] cfg_wdata;

  bma_sample_if #(.SAMPLE_BITS(SAMPLE_BITS_DEF)) smp_if ();
  bma_mean_if                                    res_if ();

  boxcar_moving_average_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .sample_i    (smp_if),
    .mean_o      (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // filter model state
  logic [SAMPLE_BITS_DEF-1:0] win_ring [MAX_WINDOW_DEF];
  logic [SUM_W-1:0]           win_sum;
  logic [5:0]                 next_slot;
  logic [SAMPLE_BITS_DEF-1:0] prime_val;
  logic [LEN_BITS-1:0]        fill_cnt;
  logic                       win_primed;
  logic [LEN_BITS-1:0]        len_reg;

  filter_req_t          req_q[$];
  logic [MEAN_BITS-1:0] mean_expect_q[$];

  int unsigned total_samples;
  int unsigned samples_sent;
  int unsigned send_gap;
  int unsigned rdy_gap;
  int unsigned quiet;
  int unsigned err_cnt;
  int unsigned stall_cycles;
  logic        smp_fire;

  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [LEN_BITS-1:0] eff_len(logic [LEN_BITS-1:0] raw);
    if (raw == 0) return LEN_BITS'(1);
    if (raw > MAX_WINDOW_DEF) return LEN_BITS'(MAX_WINDOW_DEF);
    return raw;
  endfunction

  task automatic filter_step(input logic [SAMPLE_BITS_DEF-1:0] x,
                             output logic [MEAN_BITS-1:0] m);
    logic [LEN_BITS-1:0]        n;
    logic [SAMPLE_BITS_DEF-1:0] old;
    n = eff_len(len_reg);
    if (!win_primed) begin
      // priming: every slot counts as this sample
      win_primed = 1'b1;
      prime_val  = x;
      win_sum    = SUM_W'(n) * SUM_W'(x);
      next_slot  = '0;
      fill_cnt   = '0;
      m          = MEAN_BITS'(x);
    end else begin
      if (next_slot >= n) next_slot = '0;
      // slots not yet written since priming read as the priming value
      old = (next_slot < fill_cnt) ? win_ring[next_slot] : prime_val;
      win_sum = win_sum - SUM_W'(old) + SUM_W'(x);
      win_ring[next_slot] = x;
      m = MEAN_BITS'(win_sum / SUM_W'(n));
      if (fill_cnt < n && next_slot + 1 > fill_cnt) fill_cnt = LEN_BITS'(next_slot + 1);
      next_slot++;
      if (next_slot >= n) next_slot = '0;
    end
  endtask

  task automatic push_sample(input logic [15:0] v);
    filter_req_t r;
    r.kind  = REQ_SAMPLE;
    r.value = v;
    req_q.insert(req_q.size(), r);
    total_samples++;
  endtask

  task automatic push_len(input logic [LEN_BITS-1:0] v);
    filter_req_t r;
    r.kind  = REQ_LEN_WRITE;
    r.value = 16'(v);
    req_q.insert(req_q.size(), r);
  endtask

  function automatic logic [15:0] rand_distance();
    case ($urandom_range(0, 9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 255));
      3:       return 16'($urandom_range(16'hFF00, 16'hFFFF));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [LEN_BITS-1:0] rand_len();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return '1;
      2:       return LEN_BITS'(MAX_WINDOW_DEF);
      3:       return LEN_BITS'($urandom_range(MAX_WINDOW_DEF + 1, 126));
      4:       return LEN_BITS'(1);
      default: return LEN_BITS'($urandom_range(2, 16));
    endcase
  endfunction

  // both sides of the handshake plus the length register, driven at negedge
  always @(negedge clk) begin : req_driver
    logic                nxt_valid;
    logic [15:0]         nxt_data;
    logic                nxt_ready;
    logic                nxt_we;
    logic [LEN_BITS-1:0] nxt_wdata;
    logic                calm;
    int unsigned         pct;
    filter_req_t         r;
    nxt_valid = smp_if.valid;
    nxt_data  = smp_if.distance_sample;
    nxt_ready = res_if.ready;
    nxt_we    = 1'b0;
    nxt_wdata = cfg_wdata;
    if (rst_n) begin
      if (smp_fire) samples_sent++;
      calm = (samples_sent + CALM_ITEMS >= total_samples);
      case ((samples_sent / 128) % 4)
        0:       pct = 30;
        1:       pct = 0;
        2:       pct = 60;
        default: pct = 10;
      endcase
      if (calm) pct = 0;

      if (smp_fire && $urandom_range(99) < pct) begin
        send_gap = $urandom_range(1, 11);
      end

      if (mean_expect_q.size() == 0 && !smp_if.valid) quiet++;
      else quiet = 0;

      if (!smp_if.valid || smp_fire) begin
        nxt_valid = 1'b0;
        if (send_gap != 0) begin
          send_gap--;
        end else if (req_q.size() != 0) begin
          if (req_q[0].kind == REQ_LEN_WRITE) begin
            // length writes only once the filter has drained
            if (quiet >= QUIET_CYCLES) begin
              r         = req_q.pop_front();
              nxt_we    = 1'b1;
              nxt_wdata = r.value[LEN_BITS-1:0];
            end
          end else begin
            r         = req_q.pop_front();
            nxt_valid = 1'b1;
            nxt_data  = r.value;
          end
        end
      end

      if (rdy_gap != 0) begin
        rdy_gap--;
        nxt_ready = 1'b0;
      end else if ($urandom_range(399) < pct) begin
        rdy_gap   = $urandom_range(1, 11) - 1;
        nxt_ready = 1'b0;
      end else begin
        nxt_ready = 1'b1;
      end
    end
    smp_if.valid           <= nxt_valid;
    smp_if.distance_sample <= nxt_data;
    res_if.ready           <= nxt_ready;
    cfg_we                 <= nxt_we;
    cfg_wdata              <= nxt_wdata;
  end

  always @(posedge clk) begin : mean_monitor
    logic [MEAN_BITS-1:0] want;
    if (!rst_n) begin
      smp_fire <= 1'b0;
    end else begin
      smp_fire <= smp_if.valid && smp_if.ready;
      if (res_if.valid && res_if.ready) begin
        if (mean_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected mean, expected none, actual %h",
                   $time, res_if.mean_distance);
        end else begin
          want = mean_expect_q.pop_front();
          if (res_if.mean_distance !== want) begin
            err_cnt++;
            $display("%0t: mean_distance mismatch, expected %h, actual %h",
                     $time, want, res_if.mean_distance);
          end
        end
      end
      if (cfg_we) begin
        len_reg    = cfg_wdata;
        win_primed = 1'b0;
      end
      if (smp_if.valid && smp_if.ready) begin
        filter_step(smp_if.distance_sample, want);
        mean_expect_q.insert(mean_expect_q.size(), want);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (rst_n) begin
      if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) || cfg_we)
        stall_cycles <= 0;
      else
        stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned          n_items;
    logic [LEN_BITS-1:0]  len;
    rst_n                  = 1'b0;
    smp_if.valid           = 1'b0;
    smp_if.distance_sample = '0;
    res_if.ready           = 1'b0;
    cfg_we                 = 1'b0;
    cfg_wdata              = '0;
    smp_fire               = 1'b0;
    total_samples          = 0;
    samples_sent           = 0;
    send_gap               = 0;
    rdy_gap                = 0;
    quiet                  = 0;
    err_cnt                = 0;
    stall_cycles           = 0;
    win_sum                = '0;
    next_slot              = '0;
    prime_val              = '0;
    fill_cnt               = '0;
    win_primed             = 1'b0;
    len_reg                = WINDOW_LEN_RST;

    // reset length: prime, then extremes through more than one wrap
    push_sample(16'h1234);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0001);
    push_sample(16'h8000);
    push_sample(16'h7FFF);
    push_sample(16'hFFFE);
    push_sample(16'h00FF);
    push_sample(16'hAAAA);
    // one-sample window
    push_len(LEN_BITS'(1));
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    // widest window, all ones gives the largest sum
    push_len(LEN_BITS'(MAX_WINDOW_DEF));
    push_sample(16'hFFFF);
    push_sample(16'hFFFF);
    push_sample(16'h0000);
    // zero acts as one, all-ones clamps to the widest window
    push_len('0);
    push_sample(16'h5555);
    push_sample(16'h0003);
    push_len('1);
    push_sample(16'h0000);
    push_sample(16'hFFFF);
    // back-to-back length writes, next sample primes
    push_len(LEN_BITS'(2));
    push_len(LEN_BITS'(3));
    push_sample(16'h0100);

    // random phases: a length (mostly) then 1 to 3 * eff_len + 4 samples
    while (total_samples < 20 + RAND_SAMPLES) begin
      len = len_reg;
      if ($urandom_range(0, 4) != 0) begin
        len = rand_len();
        push_len(len);
      end
      n_items = $urandom_range(1, 3 * eff_len(len) + 4);
      repeat (n_items) push_sample(rand_distance());
    end

    @(negedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    do @(posedge clk);
    while (req_q.size() != 0 || smp_if.valid || mean_expect_q.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && mean_expect_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
